FILE: src/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg: shared constants and types
// Widths, pipeline depths and cell data words of the speed profile.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int DIST_BITS  = 24;
  localparam int FRAC_BITS  = 4;
  localparam int RATE_BITS  = 16;
  localparam int EDGE_BITS  = 16;
  localparam int SPEED_BITS = 16;
  localparam int CFG_BITS   = 24;
  localparam int IDX_BITS   = 3;

  // squared speed saturates at 2^SQ_EXP, so the root has SQ_EXP/2 + 1 bits
  localparam int SQ_EXP     = 34;
  localparam int ROOT_BITS  = SQ_EXP / 2;
  localparam int REM_BITS   = ROOT_BITS + 3;
  localparam int PROD_BITS  = RATE_BITS + DIST_BITS;
  localparam int P_BITS     = PROD_BITS + 7 + 2 * FRAC_BITS;
  localparam int RAMP_LAT   = 2 + SQ_EXP + ROOT_BITS;

  localparam logic [IDX_BITS-1:0] REG_MOVE_LENGTH = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_TOP_SPEED   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_ACCEL_RATE  = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_DECEL_RATE  = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_EDGES       = 3'd4;

  typedef struct packed {
    logic [EDGE_BITS-1:0] rem;
    logic [SQ_EXP-1:0]    w;
    logic                 sat;
  } div_t;

  typedef struct packed {
    logic [SQ_EXP-1:0]    x;
    logic [REM_BITS-1:0]  r;
    logic [ROOT_BITS-1:0] q;
    logic                 sat;
  } sqrt_t;

endpackage

FILE: src/trapezoid_speed_by_distance.sv
// ----------------------------------------------------------------------------
// trapezoid_speed_by_distance: target speed of a trapezoidal move by distance
// Speed is min(top, sqrt ramp up/down), zeroed outside the move or deadband.
// ----------------------------------------------------------------------------
// Usage:
//   Write the plan through cfg_we / cfg_index / cfg_data while no query is in
//   flight: 0 move_length, 1 top_speed, 2 accel_rate, 3 decel_rate,
//   4 edges_per_turn. Unknown indexes are dropped.
//   Present distance_done with start high; busy is always low, so every
//   start beat is taken, one per cycle.
//   Each result appears on target_speed for one cycle with done high;
//   done rises once its start beat has passed the valid pipeline and the
//   output register. Beats leave in order.
//   Throughput is one beat per cycle: every step of the divider (34 cells)
//   and of the square root (17 cells) is its own pipeline cell, and both
//   ramps have their own chain.
//   Reset clears the pipeline valid bits and loads the reset plan
//   (length 0, top 0, rates and edges 1); results in flight are dropped.
//   The receiver cannot stall; done is never held off.
// ----------------------------------------------------------------------------
module trapezoid_speed_by_distance (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tsd_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [tsd_pkg::CFG_BITS-1:0]   cfg_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [tsd_pkg::DIST_BITS-1:0]  distance_done,
  output logic                           done,
  output logic [tsd_pkg::SPEED_BITS-1:0] target_speed
);

  logic [tsd_pkg::DIST_BITS-1:0]  move_length;
  logic [tsd_pkg::SPEED_BITS-1:0] top_speed;
  logic [tsd_pkg::RATE_BITS-1:0]  accel_rate;
  logic [tsd_pkg::RATE_BITS-1:0]  decel_rate;
  logic [tsd_pkg::EDGE_BITS-1:0]  edges_per_turn;

  logic [tsd_pkg::DIST_BITS-1:0]  dist_up;
  logic [tsd_pkg::DIST_BITS-1:0]  dist_down;
  logic                           gate_next;
  logic                           valid_pipe [0:tsd_pkg::RAMP_LAT];
  logic                           gate_pipe  [0:tsd_pkg::RAMP_LAT];
  logic [tsd_pkg::ROOT_BITS:0]    root_up;
  logic [tsd_pkg::ROOT_BITS:0]    root_down;
  logic [tsd_pkg::ROOT_BITS:0]    speed_min;
  logic [tsd_pkg::SPEED_BITS-1:0] speed_next;
  logic                           out_gate;

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      move_length    <= '0;
      top_speed      <= '0;
      accel_rate     <= tsd_pkg::RATE_BITS'(1);
      decel_rate     <= tsd_pkg::RATE_BITS'(1);
      edges_per_turn <= tsd_pkg::EDGE_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsd_pkg::REG_MOVE_LENGTH: move_length    <= cfg_data[tsd_pkg::DIST_BITS-1:0];
        tsd_pkg::REG_TOP_SPEED:   top_speed      <= cfg_data[tsd_pkg::SPEED_BITS-1:0];
        tsd_pkg::REG_ACCEL_RATE:  accel_rate     <= cfg_data[tsd_pkg::RATE_BITS-1:0];
        tsd_pkg::REG_DECEL_RATE:  decel_rate     <= cfg_data[tsd_pkg::RATE_BITS-1:0];
        tsd_pkg::REG_EDGES:       edges_per_turn <= cfg_data[tsd_pkg::EDGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // the move is live only strictly between start and end of a valid plan
  assign gate_next = (move_length != '0) && (top_speed != '0) && (edges_per_turn != '0)
                     && (distance_done != '0) && (distance_done < move_length);

  // register the query and the remaining distance
  always_ff @(posedge clk) begin
    dist_up   <= distance_done;
    dist_down <= move_length - distance_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe[0] <= 1'b0;
    end else begin
      valid_pipe[0] <= start && !busy;
    end
    gate_pipe[0] <= gate_next;
  end

  for (genvar k = 1; k <= tsd_pkg::RAMP_LAT; k++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) begin
        valid_pipe[k] <= 1'b0;
      end else begin
        valid_pipe[k] <= valid_pipe[k-1];
      end
      gate_pipe[k] <= gate_pipe[k-1];
    end
  end

  tsd_ramp u_up (
    .clk     (clk),
    .rate    (accel_rate),
    .edges   (edges_per_turn),
    .distance(dist_up),
    .root    (root_up)
  );

  tsd_ramp u_down (
    .clk     (clk),
    .rate    (decel_rate),
    .edges   (edges_per_turn),
    .distance(dist_down),
    .root    (root_down)
  );

  // lowest of the three limits, then deadband below 0.5 rpm and gating
  always_comb begin
    speed_min = {2'b00, top_speed};
    if (root_up < speed_min) begin
      speed_min = root_up;
    end
    if (root_down < speed_min) begin
      speed_min = root_down;
    end
    speed_next = speed_min[tsd_pkg::SPEED_BITS-1:0];
    if (({speed_min, 1'b0} < ((tsd_pkg::ROOT_BITS + 2)'(1) << tsd_pkg::FRAC_BITS))
        || !gate_pipe[tsd_pkg::RAMP_LAT]) begin
      speed_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_pipe[tsd_pkg::RAMP_LAT];
    end
    target_speed <= speed_next;
    out_gate     <= gate_pipe[tsd_pkg::RAMP_LAT];
  end

`ifndef NO_ASSERTIONS
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_gated_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !out_gate) |-> (target_speed == '0))
    else $error("speed outside the move is not zero");
  a_deadband: assert property (@(posedge clk) disable iff (rst)
    (done && (target_speed != '0)) |->
      ({target_speed, 1'b0} >= ((tsd_pkg::SPEED_BITS + 1)'(1) << tsd_pkg::FRAC_BITS)))
    else $error("speed inside deadband");
`endif

endmodule

FILE: src/tsd_div_cell.sv
// ----------------------------------------------------------------------------
// tsd_div_cell: one restoring division step
// Shifts one dividend bit into the remainder and one quotient bit into w.
// ----------------------------------------------------------------------------
module tsd_div_cell (
  input  logic                          clk,
  input  logic [tsd_pkg::EDGE_BITS-1:0] divisor,
  input  tsd_pkg::div_t                 din,
  output tsd_pkg::div_t                 dout
);

  logic [tsd_pkg::EDGE_BITS:0] trial;
  logic [tsd_pkg::EDGE_BITS:0] diff;
  logic                        take;
  tsd_pkg::div_t               dout_next;

  always_comb begin
    trial = {din.rem, din.w[tsd_pkg::SQ_EXP-1]};
    diff  = trial - {1'b0, divisor};
    take  = (trial >= {1'b0, divisor});
    dout_next.rem = take ? diff[tsd_pkg::EDGE_BITS-1:0] : trial[tsd_pkg::EDGE_BITS-1:0];
    dout_next.w   = {din.w[tsd_pkg::SQ_EXP-2:0], take};
    dout_next.sat = din.sat;
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

FILE: src/tsd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// tsd_sqrt_cell: one digit-by-digit square root step
// Takes two radicand bits and settles one root bit.
// ----------------------------------------------------------------------------
module tsd_sqrt_cell (
  input  logic           clk,
  input  tsd_pkg::sqrt_t din,
  output tsd_pkg::sqrt_t dout
);

  logic [tsd_pkg::REM_BITS-1:0] r_sh;
  logic [tsd_pkg::REM_BITS-1:0] trial;
  logic                         take;
  tsd_pkg::sqrt_t               dout_next;

  always_comb begin
    r_sh  = {din.r[tsd_pkg::REM_BITS-3:0], din.x[tsd_pkg::SQ_EXP-1 -: 2]};
    trial = {1'b0, din.q, 2'b01};
    take  = (r_sh >= trial);
    dout_next.r   = take ? (r_sh - trial) : r_sh;
    dout_next.q   = {din.q[tsd_pkg::ROOT_BITS-2:0], take};
    dout_next.x   = {din.x[tsd_pkg::SQ_EXP-3:0], 2'b00};
    dout_next.sat = din.sat;
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
  end

endmodule

FILE: src/tsd_ramp.sv
// ----------------------------------------------------------------------------
// tsd_ramp: ramp speed floor(sqrt(min(2^(2F)*120*rate*dist/e, 2^34)))
// Multiply, then a row of divider cells, then a row of root cells.
// ----------------------------------------------------------------------------
module tsd_ramp (
  input  logic                          clk,
  input  logic [tsd_pkg::RATE_BITS-1:0] rate,
  input  logic [tsd_pkg::EDGE_BITS-1:0] edges,
  input  logic [tsd_pkg::DIST_BITS-1:0] distance,
  output logic [tsd_pkg::ROOT_BITS:0]   root
);

  logic [tsd_pkg::PROD_BITS-1:0] prod;
  logic [tsd_pkg::P_BITS-1:0]    p_full;
  logic [tsd_pkg::P_BITS-1:0]    p_hi;
  tsd_pkg::div_t                 div_init;
  tsd_pkg::div_t                 div_chain [0:tsd_pkg::SQ_EXP];
  tsd_pkg::sqrt_t                sq_chain  [0:tsd_pkg::ROOT_BITS];

  always_ff @(posedge clk) begin
    prod <= tsd_pkg::PROD_BITS'(rate) * tsd_pkg::PROD_BITS'(distance);
  end

  always_comb begin
    // 120 * prod = 128 * prod - 8 * prod, then scale by 2^(2F)
    p_full = ((tsd_pkg::P_BITS'(prod) << 7) - (tsd_pkg::P_BITS'(prod) << 3))
             << (2 * tsd_pkg::FRAC_BITS);
    p_hi   = p_full >> tsd_pkg::SQ_EXP;
    div_init.sat = (p_hi >= tsd_pkg::P_BITS'(edges));
    div_init.rem = p_hi[tsd_pkg::EDGE_BITS-1:0];
    div_init.w   = p_full[tsd_pkg::SQ_EXP-1:0];
  end

  always_ff @(posedge clk) begin
    div_chain[0] <= div_init;
  end

  for (genvar k = 0; k < tsd_pkg::SQ_EXP; k++) begin : g_div
    tsd_div_cell u_cell (
      .clk    (clk),
      .divisor(edges),
      .din    (div_chain[k]),
      .dout   (div_chain[k+1])
    );
  end

  always_comb begin
    sq_chain[0].x   = div_chain[tsd_pkg::SQ_EXP].w;
    sq_chain[0].r   = '0;
    sq_chain[0].q   = '0;
    sq_chain[0].sat = div_chain[tsd_pkg::SQ_EXP].sat;
  end

  for (genvar k = 0; k < tsd_pkg::ROOT_BITS; k++) begin : g_sqrt
    tsd_sqrt_cell u_cell (
      .clk (clk),
      .din (sq_chain[k]),
      .dout(sq_chain[k+1])
    );
  end

  // saturated square root is exactly 2^(SQ_EXP/2)
  assign root = sq_chain[tsd_pkg::ROOT_BITS].sat ? {1'b1, {tsd_pkg::ROOT_BITS{1'b0}}}
                                                  : {1'b0, sq_chain[tsd_pkg::ROOT_BITS].q};

endmodule

FILE: tb/trapezoid_speed_by_distance_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoid_speed_by_distance_tb: self-checking bench for the speed profile
// Drives distance beats under several plans, predicts each target speed with
// an independent integer model and checks every done beat in order.
// ----------------------------------------------------------------------------
module trapezoid_speed_by_distance_tb;

  localparam int CYCLE_LIMIT = 400000;
  // pipeline depth plus margin; every beat gives one result
  localparam int DRAIN_CYCLES = 70;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [tsd_pkg::IDX_BITS-1:0]   cfg_index = '0;
  logic [tsd_pkg::CFG_BITS-1:0]   cfg_data = '0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [tsd_pkg::DIST_BITS-1:0]  distance_done = '0;
  logic                           done;
  logic [tsd_pkg::SPEED_BITS-1:0] target_speed;

  trapezoid_speed_by_distance dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .start(start), .busy(busy),
    .distance_done(distance_done), .done(done), .target_speed(target_speed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // plan copy held by the bench
  logic [tsd_pkg::DIST_BITS-1:0] plan_len;
  logic [15:0]                   plan_top, plan_acc, plan_dec, plan_edges;

  logic [tsd_pkg::SPEED_BITS-1:0] speed_q[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  // floor of the square root, bit by bit
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 34;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // ramp speed sqrt(2^(2F) * 120 * rate * dist / edges), squared value capped
  function automatic longint unsigned ramp_limit(longint unsigned rate,
                                                 longint unsigned dist_n,
                                                 longint unsigned e);
    longint unsigned p, q, r, sq;
    p = 120 * rate * dist_n;
    q = p / e;
    r = p % e;
    if (q >= ((64'd1 << 34) >> (2 * tsd_pkg::FRAC_BITS))) begin
      sq = 64'd1 << 34;
    end else begin
      sq = (q << (2 * tsd_pkg::FRAC_BITS)) + ((r << (2 * tsd_pkg::FRAC_BITS)) / e);
      if (sq > (64'd1 << 34)) sq = 64'd1 << 34;
    end
    return root_floor(sq);
  endfunction

  function automatic logic [tsd_pkg::SPEED_BITS-1:0] profile_speed(
      logic [tsd_pkg::DIST_BITS-1:0] n);
    longint unsigned up, down, spd;
    spd = 0;
    if (plan_len != 0 && plan_top != 0 && plan_edges != 0 && n != 0 && n < plan_len) begin
      up = ramp_limit(plan_acc, n, plan_edges);
      down = ramp_limit(plan_dec, plan_len - n, plan_edges);
      spd = plan_top;
      if (up < spd) spd = up;
      if (down < spd) spd = down;
      // deadband below half an rpm
      if ((spd << 1) < (64'd1 << tsd_pkg::FRAC_BITS)) spd = 0;
    end
    if (spd > 64'hFFFF) spd = 64'hFFFF;
    return spd[tsd_pkg::SPEED_BITS-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // check each done beat against the oldest predicted speed
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (speed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", target_speed));
      end else begin
        if (target_speed !== speed_q[0])
          report_mismatch($sformatf("target_speed %h, want %h", target_speed, speed_q[0]));
        void'(speed_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // write one register; hold the plan copy in step, masking to width
  task automatic write_reg(input logic [tsd_pkg::IDX_BITS-1:0] idx,
                           input logic [tsd_pkg::CFG_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tsd_pkg::REG_MOVE_LENGTH: plan_len = val;
      tsd_pkg::REG_TOP_SPEED:   plan_top = val[15:0];
      tsd_pkg::REG_ACCEL_RATE:  plan_acc = val[15:0];
      tsd_pkg::REG_DECEL_RATE:  plan_dec = val[15:0];
      tsd_pkg::REG_EDGES:       plan_edges = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_plan(input logic [tsd_pkg::CFG_BITS-1:0] len,
                          input logic [tsd_pkg::CFG_BITS-1:0] top,
                          input logic [tsd_pkg::CFG_BITS-1:0] acc,
                          input logic [tsd_pkg::CFG_BITS-1:0] dec,
                          input logic [tsd_pkg::CFG_BITS-1:0] edg);
    write_reg(tsd_pkg::REG_MOVE_LENGTH, len);
    write_reg(tsd_pkg::REG_TOP_SPEED, top);
    write_reg(tsd_pkg::REG_ACCEL_RATE, acc);
    write_reg(tsd_pkg::REG_DECEL_RATE, dec);
    write_reg(tsd_pkg::REG_EDGES, edg);
  endtask

  // send one distance beat; entered and left just after a falling edge
  task automatic send_distance(input logic [tsd_pkg::DIST_BITS-1:0] d);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    distance_done <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    speed_q.push_back(profile_speed(d));
    @(negedge clk);
  endtask

  // drop start and let every result in flight come back
  task automatic drain;
    start <= 1'b0;
    while (speed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_reset_plan;
    // reset plan has zero length and top: everything is zero
    send_distance(24'd0);
    send_distance(24'd1);
    send_distance(24'hFFFFFF);
    drain();
  endtask

  task automatic test_directed;
    set_plan(24'd100000, 24'd16000, 24'd5000, 24'd3000, 24'd4000);
    send_distance(24'd0);
    send_distance(24'd1);
    send_distance(24'd50000);
    send_distance(24'd99999);
    send_distance(24'd100000);
    send_distance(24'd100001);
    send_distance(24'hFFFFFF);
    drain();
    // saturation: huge rates, small edges, full-scale top
    set_plan(24'hFFFFFF, 24'hFFFF, 24'hFFFF, 24'hFFFF, 24'd1);
    send_distance(24'h7FFFFF);
    send_distance(24'hFFFFFE);
    send_distance(24'd1);
    drain();
    // deadband: slow ramps, many edges
    set_plan(24'd1000, 24'd800, 24'd1, 24'd1, 24'hFFFF);
    send_distance(24'd1);
    send_distance(24'd500);
    send_distance(24'd999);
    drain();
    // zero rates and zero edges flatten the result
    write_reg(tsd_pkg::REG_ACCEL_RATE, '0);
    send_distance(24'd500);
    drain();
    write_reg(tsd_pkg::REG_ACCEL_RATE, 24'd100);
    write_reg(tsd_pkg::REG_DECEL_RATE, '0);
    send_distance(24'd500);
    drain();
    write_reg(tsd_pkg::REG_DECEL_RATE, 24'd100);
    write_reg(tsd_pkg::REG_EDGES, '0);
    send_distance(24'd500);
    drain();
    // wide writes keep the register width; unknown indexes are ignored
    write_reg(tsd_pkg::REG_EDGES, 24'hAB0010);
    write_reg(tsd_pkg::REG_TOP_SPEED, 24'hFF0200);
    write_reg(3'd5, 24'h000001);
    write_reg(3'd6, 24'hFFFFFF);
    write_reg(3'd7, 24'h123456);
    send_distance(24'd500);
    send_distance(24'd10);
    drain();
  endtask

  // one plan per phase; most distances fall inside the move
  task automatic test_random_phase(input int beats, input int pct);
    logic [tsd_pkg::DIST_BITS-1:0] len, d;
    int sel;
    idle_pct = pct;
    sel = int'($urandom_range(3));
    case (sel)
      0: len = tsd_pkg::DIST_BITS'($urandom_range(1, 2000));
      1: len = tsd_pkg::DIST_BITS'($urandom_range(1, 200000));
      default: len = tsd_pkg::DIST_BITS'($urandom);
    endcase
    if ($urandom_range(9) == 0) len = 24'hFFFFFF;
    set_plan(len, tsd_pkg::CFG_BITS'($urandom),
             tsd_pkg::CFG_BITS'($urandom_range(0, 65535)),
             tsd_pkg::CFG_BITS'($urandom_range(0, 65535)),
             tsd_pkg::CFG_BITS'(($urandom_range(3) == 0) ? $urandom_range(1, 64)
                                                          : $urandom));
    for (int i = 0; i < beats; i++) begin
      sel = int'($urandom_range(9));
      if (sel < 7) d = tsd_pkg::DIST_BITS'($urandom_range(0, len));
      else if (sel == 7) d = len + tsd_pkg::DIST_BITS'($urandom_range(0, 3));
      else d = tsd_pkg::DIST_BITS'($urandom);
      send_distance(d);
    end
    drain();
  endtask

  task automatic test_random;
    int pcts[4] = '{0, 53, 29, 0};
    for (int ph = 0; ph < 16; ph++) test_random_phase(105, pcts[ph % 4]);
  endtask

  initial begin
    plan_len = 0;
    plan_top = 0;
    plan_acc = 1;
    plan_dec = 1;
    plan_edges = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_plan();
    test_directed();
    test_random();
    if (errors == 0 && speed_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
